[design/cpvg_pkg.sv]
// Package for the circle polygon vertex generator.
// Holds the split limit, the quarter-wave cosine table and widths.
// Used by design/circle_polygon_vertex_generator.sv and its testbench; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpvg_pkg;

  // Split limit (range 1..4) and table resolution
  localparam int MAX_SPLITS    = 4;
  localparam int TABLE_SPLITS  = 4;
  localparam int QUARTER_STEPS = 8;
  localparam int K_W           = 3;

  // Widths of the shared multiplier
  localparam int MUL_A_W = 30;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  typedef logic [15:0] cos_q15_t;

  // cos(m*pi/16) in Q1.15, m = 0..8, rounded to nearest
  function automatic cos_q15_t cos_q(input logic [3:0] m);
    cos_q15_t c;
    unique case (m)
      4'd0:    c = 16'd32768;
      4'd1:    c = 16'd32138;
      4'd2:    c = 16'd30274;
      4'd3:    c = 16'd27246;
      4'd4:    c = 16'd23170;
      4'd5:    c = 16'd18205;
      4'd6:    c = 16'd12540;
      4'd7:    c = 16'd6393;
      default: c = 16'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[design/circle_polygon_vertex_generator.sv]
// Circle polygon vertex generator: after accept it forms two squares, then runs one to four
// chord tests, then emits the point words one at a time while the output is not stalled:
// 2^(k+1)+1 words, 5 to 33.
// All products go through one shared 30x17 multiplier with a registered product;
// that unit paces the run, and no new circle is taken until the closing word is loaded.
// Reset (rst_n, synchronous) returns the sequencer to idle and drops the output word.
`timescale 1ns / 1ps
`default_nettype none

module circle_polygon_vertex_generator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_center_x,
  input  wire logic signed [15:0] in_center_y,
  input  wire logic        [14:0] in_radius,
  input  wire logic        [15:0] in_max_side,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [16:0]      out_point_x,
  output logic signed [16:0]      out_point_y,
  output logic                    out_last_point,
  output logic                    out_split_capped
);
  import cpvg_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RSQ  = 4'd1;
  localparam logic [3:0] S_SSQ  = 4'd2;
  localparam logic [3:0] S_S2   = 4'd3;
  localparam logic [3:0] S_CMUL = 4'd4;
  localparam logic [3:0] S_CMP  = 4'd5;
  localparam logic [3:0] S_PX   = 4'd6;
  localparam logic [3:0] S_PY   = 4'd7;
  localparam logic [3:0] S_PO   = 4'd8;

  logic [3:0]                state_r, state_nxt;
  logic [K_W-1:0]            k_r, k_nxt;
  logic [5:0]                idx_r, idx_nxt;
  logic                      capped_r, capped_nxt;
  logic signed [15:0]        cx_r, cy_r;
  logic [14:0]               rad_r;
  logic [15:0]               side_r;
  logic [29:0]               r2_r, r2_nxt;
  logic [31:0]               s2_r, s2_nxt;
  logic signed [16:0]        ox_r, ox_nxt;
  logic [PROD_W-1:0]         prod_r;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;

  logic                      out_valid_r;
  logic signed [16:0]        out_x_r, out_y_r;
  logic                      out_last_r, out_capped_r;
  logic                      out_free;
  logic                      out_load;

  logic                      accept;
  cos_q15_t                  chord_cos;
  logic [15:0]               chord_diff;
  logic [MUL_B_W-1:0]        chord_d;
  logic                      too_long;
  logic [5:0]                last_idx;
  logic                      is_last;
  logic [4:0]                ang;
  cos_q15_t                  c_m, c_rev;
  cos_q15_t                  ex, ey;
  logic                      xneg, yneg;
  logic [30:0]               rnd_sum;
  logic [15:0]               mag;
  logic signed [16:0]        oy;
  logic signed [16:0]        px, py;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Chord weight 2*(1 - cos a) in Q1.15 for step angle pi/2^k
  assign chord_cos  = cos_q(4'(5'd16 >> k_r));
  assign chord_diff = 16'(17'd32768 - 17'(chord_cos));
  assign chord_d    = {chord_diff, 1'b0};
  assign too_long   = prod_r > {s2_r, 15'd0};

  // Point angle in sixteenths of a half turn, split into quadrant and step
  assign ang      = 5'(idx_r << (K_W'(TABLE_SPLITS) - k_r));
  assign c_m      = cos_q({1'b0, ang[2:0]});
  assign c_rev    = cos_q(4'(QUARTER_STEPS) - {1'b0, ang[2:0]});
  assign last_idx = 6'd1 << (k_r + K_W'(1));
  assign is_last  = (idx_r == last_idx);

  always_comb begin
    unique case (ang[4:3])
      2'd0: begin
        ex = c_m;   xneg = 1'b0; ey = c_rev; yneg = 1'b0;
      end
      2'd1: begin
        ex = c_rev; xneg = 1'b1; ey = c_m;   yneg = 1'b0;
      end
      2'd2: begin
        ex = c_m;   xneg = 1'b1; ey = c_rev; yneg = 1'b1;
      end
      default: begin
        ex = c_rev; xneg = 1'b0; ey = c_m;   yneg = 1'b1;
      end
    endcase
  end

  // Round the Q1.15 product to the nearest unit on the magnitude
  assign rnd_sum = prod_r[30:0] + 31'd16384;
  assign mag     = rnd_sum[30:15];
  assign oy      = yneg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign px      = $signed({cx_r[15], cx_r}) + ox_r;
  assign py      = $signed({cy_r[15], cy_r}) + oy;

  assign out_load = (state_r == S_PO) && out_free;

  // Sequencer and shared multiplier operand select
  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    idx_nxt    = idx_r;
    capped_nxt = capped_r;
    r2_nxt     = r2_r;
    s2_nxt     = s2_r;
    ox_nxt     = ox_r;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          k_nxt     = K_W'(1);
          state_nxt = S_RSQ;
        end
      end
      S_RSQ: begin
        mul_a     = MUL_A_W'(rad_r);
        mul_b     = MUL_B_W'(rad_r);
        state_nxt = S_SSQ;
      end
      S_SSQ: begin
        r2_nxt    = prod_r[29:0];
        mul_a     = MUL_A_W'(side_r);
        mul_b     = MUL_B_W'(side_r);
        state_nxt = S_S2;
      end
      S_S2: begin
        s2_nxt    = prod_r[31:0];
        mul_a     = r2_r;
        mul_b     = chord_d;
        state_nxt = S_CMP;
      end
      S_CMUL: begin
        mul_a     = r2_r;
        mul_b     = chord_d;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (too_long && (k_r < K_W'(MAX_SPLITS))) begin
          k_nxt     = k_r + K_W'(1);
          state_nxt = S_CMUL;
        end else begin
          capped_nxt = too_long;
          idx_nxt    = '0;
          state_nxt  = S_PX;
        end
      end
      S_PX: begin
        mul_a     = MUL_A_W'(rad_r);
        mul_b     = MUL_B_W'(ex);
        state_nxt = S_PY;
      end
      S_PY: begin
        ox_nxt    = xneg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        mul_a     = MUL_A_W'(rad_r);
        mul_b     = MUL_B_W'(ey);
        state_nxt = S_PO;
      end
      S_PO: begin
        // Hold the y product until the output register is free
        mul_a = MUL_A_W'(rad_r);
        mul_b = MUL_B_W'(ey);
        if (out_free) begin
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 6'd1;
            state_nxt = S_PX;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= K_W'(1);
      idx_r       <= '0;
      capped_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      idx_r    <= idx_nxt;
      capped_r <= capped_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: captured circle, squares, product, output word
  always_ff @(posedge clk) begin
    if (accept) begin
      cx_r   <= in_center_x;
      cy_r   <= in_center_y;
      rad_r  <= in_radius;
      side_r <= in_max_side;
    end
    r2_r   <= r2_nxt;
    s2_r   <= s2_nxt;
    ox_r   <= ox_nxt;
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (out_load) begin
      out_x_r      <= px;
      out_y_r      <= py;
      out_last_r   <= is_last;
      out_capped_r <= capped_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_point_x      = out_x_r;
  assign out_point_y      = out_y_r;
  assign out_last_point   = out_last_r;
  assign out_split_capped = out_capped_r;

  // Split count stays within 1..MAX_SPLITS
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (k_r >= K_W'(1)) && (k_r <= K_W'(MAX_SPLITS)))
    else $error("split count out of range");

  // Point index never runs past the closing point
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PX || state_r == S_PY || state_r == S_PO) |-> (idx_r <= last_idx))
    else $error("point index past closing point");

  // An accepted word starts the squaring step
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_RSQ))
    else $error("accepted word did not start the run");

  // Only a point that is loaded at the last index is marked closing
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_last_point == (state_r == S_IDLE)))
    else $error("closing flag disagrees with sequencer");

endmodule

`default_nettype wire

[tb/circle_polygon_vertex_generator_test.sv]
// Self-checking testbench for circle_polygon_vertex_generator.
// Drives circles through the input channel and checks every perimeter point
// against a local predictor. Depends on design/cpvg_pkg.sv and the block RTL.
`timescale 1ns / 1ps

module circle_polygon_vertex_generator_test;
  import cpvg_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int IDLE_PCT    = 16;
  localparam int RANDOM_CIRCLES = 250;

  typedef struct {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic               closing;
    logic               capped;
    int unsigned        circle;
  } vertex_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_center_x;
  logic signed [15:0] in_center_y;
  logic        [14:0] in_radius;
  logic        [15:0] in_max_side;
  logic               out_valid;
  logic               out_stall;
  logic signed [16:0] out_point_x;
  logic signed [16:0] out_point_y;
  logic               out_last_point;
  logic               out_split_capped;

  vertex_t     pending_vertices[$];
  int unsigned errors;
  int unsigned circles_sent;
  int unsigned points_checked;
  int unsigned capped_runs;
  int unsigned depth_count[1:4];
  int unsigned quiet_cycles;
  bit          calm;

  circle_polygon_vertex_generator DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_radius        (in_radius),
    .in_max_side      (in_max_side),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_last_point   (out_last_point),
    .out_split_capped (out_split_capped)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // cos(m*pi/16) magnitude in Q1.15
  function automatic longint unsigned quarter_cos(input int unsigned m);
    longint unsigned c;
    case (m)
      0:       c = 32768;
      1:       c = 32138;
      2:       c = 30274;
      3:       c = 27246;
      4:       c = 23170;
      5:       c = 18205;
      6:       c = 12540;
      7:       c = 6393;
      default: c = 0;
    endcase
    return c;
  endfunction

  // Squared chord at step pi/2^k against the squared side limit, exact
  function automatic bit chord_exceeds(input longint unsigned r, input longint unsigned side,
                                       input int unsigned k);
    longint unsigned c;
    longint unsigned lhs;
    longint unsigned rhs;
    c   = quarter_cos((16 >> k) & 15);
    lhs = r * r * (2 * (64'd32768 - c));
    rhs = side * side * 64'd32768;
    return lhs > rhs;
  endfunction

  // Rounded r*entry, half away from zero
  function automatic int radial_offset(input longint unsigned r, input longint unsigned entry,
                                       input bit neg);
    longint unsigned mag;
    mag = (r * entry + 16384) >> 15;
    return neg ? -int'(mag) : int'(mag);
  endfunction

  // Work out every vertex of one circle and queue it
  function automatic void predict_polygon(input logic signed [15:0] cx,
                                          input logic signed [15:0] cy,
                                          input logic [14:0] r, input logic [15:0] side);
    int unsigned     k;
    int unsigned     n;
    int unsigned     j;
    int unsigned     q;
    int unsigned     m;
    bit              capped;
    int              ox;
    int              oy;
    int              px;
    int              py;
    vertex_t         v;
    longint unsigned rl;
    longint unsigned sl;
    rl = 64'(r);
    sl = 64'(side);
    k = 1;
    while (k < MAX_SPLITS && chord_exceeds(rl, sl, k)) k++;
    capped = (k == MAX_SPLITS) && chord_exceeds(rl, sl, k);
    depth_count[k]++;
    if (capped) capped_runs++;
    n = (1 << (k + 1)) + 1;
    for (int unsigned i = 0; i < n; i++) begin
      j = (i << (TABLE_SPLITS - k)) & 31;
      q = j >> 3;
      m = j & 7;
      case (q)
        0: begin
          ox = radial_offset(rl, quarter_cos(m), 1'b0);
          oy = radial_offset(rl, quarter_cos(QUARTER_STEPS - m), 1'b0);
        end
        1: begin
          ox = radial_offset(rl, quarter_cos(QUARTER_STEPS - m), 1'b1);
          oy = radial_offset(rl, quarter_cos(m), 1'b0);
        end
        2: begin
          ox = radial_offset(rl, quarter_cos(m), 1'b1);
          oy = radial_offset(rl, quarter_cos(QUARTER_STEPS - m), 1'b1);
        end
        default: begin
          ox = radial_offset(rl, quarter_cos(QUARTER_STEPS - m), 1'b0);
          oy = radial_offset(rl, quarter_cos(m), 1'b1);
        end
      endcase
      px = int'(cx) + ox;
      py = int'(cy) + oy;
      v.x       = px[16:0];
      v.y       = py[16:0];
      v.closing = (i == n - 1);
      v.capped  = capped;
      v.circle  = circles_sent;
      pending_vertices.push_back(v);
    end
  endfunction

  task automatic report_mismatch(input string field, input int unsigned circle,
                                 input longint got, input longint want);
    $display("MISMATCH circle %0d %s: got %0d, want %0d", circle, field, got, want);
    errors++;
  endtask

  // Send one circle word; idle at random first, hold until accepted
  task automatic send_circle(input logic signed [15:0] cx, input logic signed [15:0] cy,
                             input logic [14:0] r, input logic [15:0] side);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_center_x <= cx;
    in_center_y <= cy;
    in_radius   <= r;
    in_max_side <= side;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    predict_polygon(cx, cy, r, side);
    circles_sent++;
  endtask

  // Drop valid once the directed or random burst is over
  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic test_zero_radius();
    send_circle(16'sd0, 16'sd0, 15'd0, 16'd0);
    send_circle(-16'sd32768, 16'sd32767, 15'd0, 16'd65535);
    send_circle(16'sd1234, -16'sd5, 15'd0, 16'd0);
  endtask

  task automatic test_field_extremes();
    send_circle(16'sd32767, 16'sd32767, 15'd32767, 16'd0);
    send_circle(-16'sd32768, -16'sd32768, 15'd32767, 16'd0);
    send_circle(16'sd32767, -16'sd32768, 15'd32767, 16'd65535);
    send_circle(-16'sd32768, 16'sd32767, 15'd1, 16'd0);
    send_circle(16'sd0, 16'sd0, 15'd32767, 16'd65535);
    send_circle(-16'sd1, 16'sd1, 15'd16384, 16'd32768);
  endtask

  // One radius, side limits chosen to land on each split depth
  task automatic test_split_depths();
    send_circle(16'sd100, -16'sd200, 15'd1000, 16'd2000);
    send_circle(16'sd100, -16'sd200, 15'd1000, 16'd1415);
    send_circle(16'sd100, -16'sd200, 15'd1000, 16'd1414);
    send_circle(-16'sd300, 16'sd50, 15'd1000, 16'd1000);
    send_circle(-16'sd300, 16'sd50, 15'd1000, 16'd500);
    // cap reached while the chord fits: no cap flag
    send_circle(16'sd7, 16'sd9, 15'd1000, 16'd300);
    // still too long at the cap
    send_circle(16'sd7, 16'sd9, 15'd1000, 16'd100);
  endtask

  task automatic test_random_circles();
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic        [14:0] r;
    logic        [15:0] side;
    int unsigned        pick;
    int unsigned        scaled_side;
    for (int n = 0; n < RANDOM_CIRCLES; n++) begin
      // long stretch with no idling on either side
      calm = (n >= 100 && n < 160);
      cx   = 16'($urandom);
      cy   = 16'($urandom);
      pick = $urandom_range(9);
      if (pick == 0) begin
        r    = 15'($urandom);
        side = 16'($urandom);
      end else if (pick == 1) begin
        r    = 15'($urandom_range(15));
        side = 16'($urandom_range(31));
      end else begin
        r = 15'((pick == 2) ? $urandom_range(32767) : $urandom_range(2047));
        // side as a fraction of the radius spreads runs over every split depth
        scaled_side = (int'(r) * $urandom_range(170)) / 100 + $urandom_range(3);
        side = scaled_side[15:0];
      end
      send_circle(cx, cy, r, side);
    end
    calm = 1'b0;
  endtask

  // Random output stall, none during the calm stretch
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Check each accepted result word against the oldest queued vertex
  always @(posedge clk) begin
    vertex_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_vertices.size() == 0) begin
        report_mismatch("unexpected point_x", circles_sent, out_point_x, 0);
      end else begin
        want = pending_vertices.pop_front();
        points_checked++;
        if (out_point_x !== want.x)
          report_mismatch("point_x", want.circle, out_point_x, want.x);
        if (out_point_y !== want.y)
          report_mismatch("point_y", want.circle, out_point_y, want.y);
        if (out_last_point !== want.closing)
          report_mismatch("last_point", want.circle, out_last_point, want.closing);
        if (out_split_capped !== want.capped)
          report_mismatch("split_capped", want.circle, out_split_capped, want.capped);
      end
    end
  end

  // Watchdog: end the run after too long with no word moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
        $display("circle_polygon_vertex_generator verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_center_x  = '0;
    in_center_y  = '0;
    in_radius    = '0;
    in_max_side  = '0;
    errors       = 0;
    circles_sent = 0;
    points_checked = 0;
    capped_runs  = 0;
    quiet_cycles = 0;
    calm         = 1'b0;
    for (int k = 1; k <= 4; k++) depth_count[k] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_zero_radius();
    test_field_extremes();
    test_split_depths();
    test_random_circles();
    release_input();

    // drain the remaining vertices, then allow the block to settle
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d circles, %0d points; split depths 1..4: %0d %0d %0d %0d",
             circles_sent, points_checked, depth_count[1], depth_count[2],
             depth_count[3], depth_count[4]);
    $display("runs stopped at the split cap: %0d, mismatches: %0d", capped_runs, errors);
    if (errors == 0) begin
      $display("circle_polygon_vertex_generator verification clean");
    end else begin
      $display("circle_polygon_vertex_generator verification failed");
    end
    $finish;
  end

endmodule
